FILE: sv/crs_pkg.sv
// Shared constants, codes and types of the Catmull-Rom stroke smoother.
// No dependencies; every other file of the block refers to it by scoped names.
package crs_pkg;

  // Fixed-point format and sample limits
  localparam int FRAC_BITS   = 15;
  localparam int MAX_SAMPLES = 31;

  // Field widths
  localparam int PT_W   = 16;                 // input coordinate
  localparam int OUT_W  = 18;                 // output coordinate
  localparam int KIND_W = 2;
  localparam int S_W    = 5;                  // samples per segment register
  localparam int S_RST  = 8;

  // Datapath widths
  localparam int ACC_W      = 22;             // Horner accumulator, signed
  localparam int T_W        = FRAC_BITS + 1;  // t and step quotient, unsigned
  localparam int PROD_W     = ACC_W + T_W + 1;
  localparam int DIV_CNT_W  = $clog2(FRAC_BITS + 1);
  localparam int OUT_MAX    = 131071;
  localparam int OUT_MIN    = -131072;
  localparam int RND_HALF   = 1 << (FRAC_BITS - 1);

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_END    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERR    = 2'd2;

  // Horner coefficient select
  localparam logic [1:0] STEP_B  = 2'd0;
  localparam logic [1:0] STEP_A  = 2'd1;
  localparam logic [1:0] STEP_P1 = 2'd2;

  // Four control points of one coordinate, entry 0 is p0
  typedef logic [3:0][PT_W-1:0] quad_t;

  // Control of the shared Horner unit
  typedef struct packed {
    logic       load;   // acc <= c
    logic       mul;    // prod <= acc * t
    logic       add;    // acc <= rnd(prod) + coefficient
    logic [1:0] step;   // coefficient select
  } hrn_ctrl_t;

endpackage

FILE: sv/crs_if.sv
// Handshake channels of the Catmull-Rom stroke smoother: points in,
// results out, and the samples-per-segment write channel. Uses crs_pkg.
interface crs_pnt_if;
  logic                       valid;
  logic                       ready;
  logic [crs_pkg::PT_W-1:0]   x_coord;
  logic [crs_pkg::PT_W-1:0]   y_coord;
  logic                       end_of_stroke;

  modport source (output valid, x_coord, y_coord, end_of_stroke, input ready);
  modport sink   (input valid, x_coord, y_coord, end_of_stroke, output ready);
endinterface

interface crs_res_if;
  logic                              valid;
  logic                              ready;
  logic signed [crs_pkg::OUT_W-1:0]  x_out;
  logic signed [crs_pkg::OUT_W-1:0]  y_out;
  logic [crs_pkg::KIND_W-1:0]        kind;
  logic                              last_of_run;

  modport source (output valid, x_out, y_out, kind, last_of_run, input ready);
  modport sink   (input valid, x_out, y_out, kind, last_of_run, output ready);
endinterface

interface crs_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [crs_pkg::S_W-1:0]   samples_per_segment;

  modport source (output valid, samples_per_segment, input ready);
  modport sink   (input valid, samples_per_segment, output ready);
endinterface

FILE: sv/catmull_rom_stroke_smoother.sv
// Top level of the Catmull-Rom stroke smoother: point history, sequencer,
// step divider and result register. Depends on crs_pkg, crs_if, crs_horner.
//
// Points of a pen stroke enter one transaction at a time; each segment
// between neighboring points yields samples_per_segment uniform Catmull-Rom
// samples (0 reads as 1), the outer control points clamped at the stroke
// ends, and the stroke's final point adds its pending segments and the end
// point itself (a one-point stroke gives a single error result). A point
// that completes no segment is only recorded. A point that produces results
// first derives the t increment with a bit-serial divider, then computes its
// samples, each held until taken before the next starts: one shared
// multiplier runs three Horner steps per coordinate, each a multiply step
// and a round-add step, plus a load and a capture step per coordinate and
// one output step. The end or error result follows as one more result.
// The input is not ready from acceptance until its last result is taken.
module catmull_rom_stroke_smoother (
  input  logic       clk_i,
  input  logic       rst_ni,
  crs_pnt_if.sink    pnt_i,
  crs_res_if.source  res_o,
  crs_cfg_if.sink    cfg_i
);

  localparam int T_W   = crs_pkg::T_W;
  localparam int S_W   = crs_pkg::S_W;
  localparam int OUT_W = crs_pkg::OUT_W;
  localparam int PT_W  = crs_pkg::PT_W;

  // Sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_LOAD = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_ADD  = 3'd4;
  localparam logic [2:0] ST_CAP  = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;

  // Segment control-point patterns
  localparam logic [1:0] SEG_A = 2'd0;  // older, h1, h0, new
  localparam logic [1:0] SEG_B = 2'd1;  // h1, h0, new, new
  localparam logic [1:0] SEG_C = 2'd2;  // h0, h0, new, new

  logic [2:0]              state_q;
  logic [S_W-1:0]          cfg_q;
  logic [2:0][31:0]        hist_q;
  logic [1:0]              seen_q;
  logic [31:0]             np_q;
  logic                    last_q;
  logic [1:0]              seg_q;
  logic                    has2_q;
  logic                    end_q;
  logic [S_W-1:0]          j_q;
  logic [T_W-1:0]          t_q, t_d;
  logic [S_W-1:0]          r_q, r_d;
  logic [T_W-1:0]          quo_q, quo_d;
  logic [S_W-1:0]          rem_q, rem_d;
  logic [crs_pkg::DIV_CNT_W-1:0] dcnt_q;
  logic                    k_q;
  logic [1:0]              step_q;
  logic signed [OUT_W-1:0] xs_q;

  logic                    ov_q;
  logic signed [OUT_W-1:0] ox_q, oy_q;
  logic [crs_pkg::KIND_W-1:0] okind_q;
  logic                    olast_q;

  logic [S_W-1:0]          s_eff;
  logic                    seg_done;
  logic                    pnt_acc, res_acc;
  logic [31:0]             np_in, h_old;
  logic [3:0][31:0]        quad32;
  crs_pkg::quad_t          pts;
  crs_pkg::hrn_ctrl_t      hctrl;
  logic signed [OUT_W-1:0] hval;
  logic [S_W:0]            div_sh, r_sum;
  logic                    div_ge, r_carry;

  assign pnt_acc = pnt_i.valid && pnt_i.ready;
  assign res_acc = res_o.valid && res_o.ready;
  assign np_in   = {pnt_i.y_coord, pnt_i.x_coord};

  // Effective samples per segment: zero reads as one, clamp to the maximum
  always_comb begin
    if (cfg_q == '0) begin
      s_eff = S_W'(1);
    end else if (cfg_q > S_W'(crs_pkg::MAX_SAMPLES)) begin
      s_eff = S_W'(crs_pkg::MAX_SAMPLES);
    end else begin
      s_eff = cfg_q;
    end
  end

  assign seg_done = (j_q == s_eff - S_W'(1));

  // Bit-serial division of 2^FRAC_BITS by S
  assign div_sh = {rem_q, (dcnt_q == crs_pkg::DIV_CNT_W'(crs_pkg::FRAC_BITS))};
  assign div_ge = (div_sh >= {1'b0, s_eff});
  assign rem_d  = div_ge ? S_W'(div_sh - {1'b0, s_eff}) : div_sh[S_W-1:0];
  assign quo_d  = {quo_q[T_W-2:0], div_ge};

  // Advance t by 2^FRAC_BITS / S, carrying the remainder
  assign r_sum   = {1'b0, r_q} + {1'b0, rem_q};
  assign r_carry = (r_sum >= {1'b0, s_eff});
  assign r_d     = r_carry ? S_W'(r_sum - {1'b0, s_eff}) : r_sum[S_W-1:0];
  assign t_d     = t_q + quo_q + T_W'(r_carry);

  // Select the control points of the current segment and coordinate
  assign h_old = (seen_q == 2'd2) ? hist_q[1] : hist_q[2];

  always_comb begin
    unique case (seg_q)
      SEG_A:   quad32 = {np_q, hist_q[0], hist_q[1], h_old};
      SEG_B:   quad32 = {np_q, np_q, hist_q[0], hist_q[1]};
      default: quad32 = {np_q, np_q, hist_q[0], hist_q[0]};
    endcase
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      pts[i] = k_q ? quad32[i][31:16] : quad32[i][15:0];
    end
  end

  // Drive the shared Horner unit
  assign hctrl.load = (state_q == ST_LOAD);
  assign hctrl.mul  = (state_q == ST_MUL);
  assign hctrl.add  = (state_q == ST_ADD);
  assign hctrl.step = step_q;

  crs_horner u_horner (
    .clk_i  (clk_i),
    .ctrl_i (hctrl),
    .pts_i  (pts),
    .t_i    (t_q),
    .val_o  (hval)
  );

  // Configuration register: take writes only between points
  assign cfg_i.ready = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= S_W'(crs_pkg::S_RST);
    end else if (cfg_i.valid && cfg_i.ready) begin
      cfg_q <= cfg_i.samples_per_segment;
    end
  end

  // Sequencer, history and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      hist_q  <= '0;
      seen_q  <= '0;
      np_q    <= '0;
      last_q  <= 1'b0;
      seg_q   <= SEG_A;
      has2_q  <= 1'b0;
      end_q   <= 1'b0;
      j_q     <= '0;
      t_q     <= '0;
      r_q     <= '0;
      quo_q   <= '0;
      rem_q   <= '0;
      dcnt_q  <= '0;
      k_q     <= 1'b0;
      step_q  <= crs_pkg::STEP_B;
      xs_q    <= '0;
      ov_q    <= 1'b0;
      ox_q    <= '0;
      oy_q    <= '0;
      okind_q <= crs_pkg::KIND_SAMPLE;
      olast_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (pnt_acc) begin
            np_q   <= np_in;
            last_q <= pnt_i.end_of_stroke;
            quo_q  <= '0;
            rem_q  <= '0;
            dcnt_q <= crs_pkg::DIV_CNT_W'(crs_pkg::FRAC_BITS);
            if (pnt_i.end_of_stroke && seen_q == 2'd0) begin
              // Stroke too short: report and clear
              ox_q    <= '0;
              oy_q    <= '0;
              okind_q <= crs_pkg::KIND_ERR;
              olast_q <= 1'b1;
              ov_q    <= 1'b1;
              state_q <= ST_OUT;
            end else if (pnt_i.end_of_stroke && seen_q == 2'd1) begin
              seg_q   <= SEG_C;
              has2_q  <= 1'b0;
              end_q   <= 1'b1;
              state_q <= ST_DIV;
            end else if (pnt_i.end_of_stroke) begin
              seg_q   <= SEG_A;
              has2_q  <= 1'b1;
              end_q   <= 1'b1;
              state_q <= ST_DIV;
            end else if (seen_q >= 2'd2) begin
              seg_q   <= SEG_A;
              has2_q  <= 1'b0;
              end_q   <= 1'b0;
              state_q <= ST_DIV;
            end else begin
              // No segment yet: just record the point
              hist_q <= {hist_q[1], hist_q[0], np_in};
              seen_q <= seen_q + 2'd1;
            end
          end
        end

        ST_DIV: begin
          quo_q <= quo_d;
          rem_q <= rem_d;
          if (dcnt_q == '0) begin
            j_q     <= '0;
            t_q     <= '0;
            r_q     <= s_eff >> 1;
            k_q     <= 1'b0;
            state_q <= ST_LOAD;
          end else begin
            dcnt_q <= dcnt_q - crs_pkg::DIV_CNT_W'(1);
          end
        end

        ST_LOAD: begin
          step_q  <= crs_pkg::STEP_B;
          state_q <= ST_MUL;
        end

        ST_MUL: begin
          state_q <= ST_ADD;
        end

        ST_ADD: begin
          if (step_q == crs_pkg::STEP_P1) begin
            state_q <= ST_CAP;
          end else begin
            step_q  <= step_q + 2'd1;
            state_q <= ST_MUL;
          end
        end

        ST_CAP: begin
          if (!k_q) begin
            xs_q    <= hval;
            k_q     <= 1'b1;
            state_q <= ST_LOAD;
          end else begin
            ox_q    <= xs_q;
            oy_q    <= hval;
            okind_q <= crs_pkg::KIND_SAMPLE;
            olast_q <= seg_done && !has2_q && !end_q;
            ov_q    <= 1'b1;
            state_q <= ST_OUT;
          end
        end

        ST_OUT: begin
          if (res_acc) begin
            if (okind_q == crs_pkg::KIND_SAMPLE && !seg_done) begin
              // Next sample of this segment
              ov_q    <= 1'b0;
              j_q     <= j_q + S_W'(1);
              t_q     <= t_d;
              r_q     <= r_d;
              k_q     <= 1'b0;
              state_q <= ST_LOAD;
            end else if (okind_q == crs_pkg::KIND_SAMPLE && has2_q) begin
              // Closing segment of the stroke
              ov_q    <= 1'b0;
              seg_q   <= SEG_B;
              has2_q  <= 1'b0;
              j_q     <= '0;
              t_q     <= '0;
              r_q     <= s_eff >> 1;
              k_q     <= 1'b0;
              state_q <= ST_LOAD;
            end else if (okind_q == crs_pkg::KIND_SAMPLE && end_q) begin
              // Emit the stroke end point unchanged
              end_q   <= 1'b0;
              ox_q    <= $signed({{(OUT_W - PT_W){1'b0}}, np_q[15:0]});
              oy_q    <= $signed({{(OUT_W - PT_W){1'b0}}, np_q[31:16]});
              okind_q <= crs_pkg::KIND_END;
              olast_q <= 1'b1;
              ov_q    <= 1'b1;
            end else begin
              // Run complete: update history and return to idle
              ov_q <= 1'b0;
              if (last_q) begin
                hist_q <= '0;
                seen_q <= '0;
              end else begin
                hist_q <= {hist_q[1], hist_q[0], np_q};
                if (seen_q != 2'd3) begin
                  seen_q <= seen_q + 2'd1;
                end
              end
              state_q <= ST_IDLE;
            end
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Ports
  assign pnt_i.ready       = (state_q == ST_IDLE);
  assign res_o.valid       = ov_q;
  assign res_o.x_out       = ox_q;
  assign res_o.y_out       = oy_q;
  assign res_o.kind        = okind_q;
  assign res_o.last_of_run = olast_q;

endmodule

FILE: sv/crs_horner.sv
// Shared Horner unit: one multiplier, rounding shift and add, reused for all
// three steps of both coordinates. Depends on crs_pkg.
module crs_horner (
  input  logic                              clk_i,
  input  crs_pkg::hrn_ctrl_t                ctrl_i,
  input  crs_pkg::quad_t                    pts_i,
  input  logic [crs_pkg::T_W-1:0]           t_i,
  output logic signed [crs_pkg::OUT_W-1:0]  val_o
);

  localparam int ACC_W  = crs_pkg::ACC_W;
  localparam int PROD_W = crs_pkg::PROD_W;
  localparam logic signed [ACC_W-1:0] OutMaxA = ACC_W'(crs_pkg::OUT_MAX);
  localparam logic signed [ACC_W-1:0] OutMinA = ACC_W'(crs_pkg::OUT_MIN);
  localparam logic signed [ACC_W-1:0] Three   = ACC_W'(3);
  localparam logic signed [ACC_W-1:0] Five    = ACC_W'(5);
  localparam logic signed [PROD_W-1:0] RndHalf = PROD_W'(crs_pkg::RND_HALF);

  logic signed [ACC_W-1:0]  p0, p1, p2, p3;
  logic signed [ACC_W-1:0]  coef_a, coef_b, coef_c, two_p1, coef;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [PROD_W-1:0] prod_q, prod_rnd, prod_shr;
  logic signed [ACC_W-1:0]  v_inc, v_half;

  // Widen the control points
  assign p0 = $signed({{(ACC_W - crs_pkg::PT_W){1'b0}}, pts_i[0]});
  assign p1 = $signed({{(ACC_W - crs_pkg::PT_W){1'b0}}, pts_i[1]});
  assign p2 = $signed({{(ACC_W - crs_pkg::PT_W){1'b0}}, pts_i[2]});
  assign p3 = $signed({{(ACC_W - crs_pkg::PT_W){1'b0}}, pts_i[3]});

  // Catmull-Rom polynomial coefficients
  assign coef_a = p2 - p0;
  assign coef_b = (p0 <<< 1) - Five * p1 + (p2 <<< 2) - p3;
  assign coef_c = Three * p1 - p0 - Three * p2 + p3;
  assign two_p1 = p1 <<< 1;

  always_comb begin
    case (ctrl_i.step)
      crs_pkg::STEP_B:  coef = coef_b;
      crs_pkg::STEP_A:  coef = coef_a;
      default:          coef = two_p1;
    endcase
  end

  // Round to nearest, ties up, then add the next coefficient
  assign prod_rnd = prod_q + RndHalf;
  assign prod_shr = prod_rnd >>> crs_pkg::FRAC_BITS;
  assign acc_d    = prod_shr[ACC_W-1:0] + coef;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      acc_q <= coef_c;
    end else if (ctrl_i.add) begin
      acc_q <= acc_d;
    end
    if (ctrl_i.mul) begin
      prod_q <= acc_q * $signed({1'b0, t_i});
    end
  end

  // Halve with rounding to nearest, ties up, and saturate to the output range
  assign v_inc  = acc_q + ACC_W'(1);
  assign v_half = v_inc >>> 1;

  always_comb begin
    if (v_half > OutMaxA) begin
      val_o = OutMaxA[crs_pkg::OUT_W-1:0];
    end else if (v_half < OutMinA) begin
      val_o = OutMinA[crs_pkg::OUT_W-1:0];
    end else begin
      val_o = v_half[crs_pkg::OUT_W-1:0];
    end
  end

endmodule

FILE: sv/crs_checker.sv
// Port-level checks of the Catmull-Rom stroke smoother, bound to the top
// level. Depends on crs_pkg and catmull_rom_stroke_smoother.
module crs_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              pnt_ready_i,
  input logic                              res_valid_i,
  input logic                              res_ready_i,
  input logic signed [crs_pkg::OUT_W-1:0]  res_x_i,
  input logic signed [crs_pkg::OUT_W-1:0]  res_y_i,
  input logic [crs_pkg::KIND_W-1:0]        res_kind_i,
  input logic                              res_last_i
);

  // Hold a stalled result
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_x_i) &&
    $stable(res_y_i) && $stable(res_kind_i) && $stable(res_last_i))
    else $error("stalled result changed");

  // Points are refused while a result is pending
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> !pnt_ready_i)
    else $error("point accepted while result pending");

  // End and error results close the run
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (res_kind_i == crs_pkg::KIND_END ||
    res_kind_i == crs_pkg::KIND_ERR) |-> res_last_i)
    else $error("end or error result not last of run");

  // Error results carry zero coordinates
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_kind_i == crs_pkg::KIND_ERR |->
    res_x_i == '0 && res_y_i == '0)
    else $error("error result with nonzero coordinates");

endmodule

bind catmull_rom_stroke_smoother crs_checker u_crs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .pnt_ready_i (pnt_i.ready),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_x_i     (res_o.x_out),
  .res_y_i     (res_o.y_out),
  .res_kind_i  (res_o.kind),
  .res_last_i  (res_o.last_of_run)
);
